// ----- rtl/core/rde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and constants of the repeating decimal expander.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int NUM_W           = 16;  // numerator field width
  localparam int DEN_W           = 12;  // denominator field width
  localparam int VALUE_W         = 16;  // result value width
  localparam int DIGIT_W         = 4;   // one decimal digit
  localparam int POS_W           = 13;  // digit positions up to 2**DEN_W + 1
  localparam int EPOCH_W         = 8;   // remainder table tag width
  localparam int STORE_DEPTH     = 64;  // digit store entries
  localparam int STORE_AW        = 6;
  localparam int MAX_DIGIT_ITEMS = 62;  // a run holds at most 64 items

  typedef enum logic [1:0] {
    KIND_INT = 2'd0,
    KIND_PRE = 2'd1,
    KIND_CYC = 2'd2,
    KIND_SUM = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT_INT,
    ST_EMIT_RD,
    ST_EMIT_DIG,
    ST_EMIT_SUM
  } state_e;

  // One remainder table entry: tag of the fraction that wrote it, and the
  // digit position at which that remainder was first seen.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [POS_W-1:0]   pos;
  } rt_entry_t;

  // Write port of the digit store.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [DIGIT_W-1:0]  data;
  } dig_wr_t;

endpackage

// ----- rtl/core/rde_intdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_intdiv
// Restoring divider, one quotient bit per cycle: integer part and first
// remainder of the fraction.
// ----------------------------------------------------------------------------
module rde_intdiv
  import rde_pkg::*;
#(
  parameter int NB = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NB-1:0]    num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NB-1:0]    quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]    quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // quo_q shifts the dividend out at the top and the quotient in at the bottom
  assign rem_sh  = {rem_q, quo_q[NB-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NB-2:0], ge};
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/rde_remtable.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_remtable
// Remainder table: first digit position of each remainder, tagged with the
// fraction that wrote it. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rde_remtable
  import rde_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output rt_entry_t     rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  rt_entry_t     wr_data_i
);

  rt_entry_t mem [DEPTH];
  rt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/rde_digits.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_digits
// Digit store: the first decimal digits of the expansion, written during
// the walk and read back while the run goes out.
// ----------------------------------------------------------------------------
module rde_digits
  import rde_pkg::*;
(
  input  logic                clk_i,
  input  dig_wr_t             wr_i,
  input  logic                rd_en_i,
  input  logic [STORE_AW-1:0] rd_addr_i,
  output logic [DIGIT_W-1:0]  rd_data_o
);

  logic [DIGIT_W-1:0] mem [STORE_DEPTH];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/repeating_decimal_expander_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_decimal_expander_top
// Long-divides one fraction per input transaction and streams out the
// integer part, pre-cycle digits, cycle digits and a cycle summary.
// ----------------------------------------------------------------------------
// One fraction is worked at a time. A fraction goes first through the
// bit-serial integer divider, then through the walk, with one read and one
// write-back of the remainder table per digit step (the table read is
// registered), at most denominator + 1 steps; the run then goes out as the
// integer part, one digit store read per digit, and the summary. A zero
// denominator, or one above TABLE_DEPTH, yields only a summary with
// bad_input set. Table entries are tagged per fraction instead of cleared;
// after reset and after every 255 good fractions a clearing pass over all
// TABLE_DEPTH entries runs, during which no fraction is accepted.
module repeating_decimal_expander_top
  import rde_pkg::*;
#(
  parameter int TABLE_DEPTH        = 4096,
  parameter int SHOWN_CYCLE_DIGITS = 50,
  parameter int NUMERATOR_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // numerator[15:0], denominator[27:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // value[15:0], truncated[16], bad_input[17]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int TAB_AW  = $clog2(TABLE_DEPTH);
  localparam int NB_USED = (NUMERATOR_BITS < NUM_W) ? NUMERATOR_BITS : NUM_W;
  localparam int T_W     = DEN_W + 5;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [DEN_W-1:0]   rem;
  } digit_res_t;

  // One digit step: 10*r divided by d, quotient known to stay below 16.
  function automatic digit_res_t digit_step(input logic [DEN_W-1:0] r,
                                            input logic [DEN_W-1:0] d);
    logic [T_W-1:0] t;
    logic [T_W-1:0] dd;
    digit_res_t     res;
    t = {2'b00, r, 3'b000} + {4'b0000, r, 1'b0};
    res.digit = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      dd = T_W'(d) << i;
      if (t >= dd) begin
        t = t - dd;
        res.digit[i] = 1'b1;
      end
    end
    res.rem = t[DEN_W-1:0];
    return res;
  endfunction

  state_e              state_q, state_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic                bad_q, bad_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [TAB_AW-1:0]   clr_addr_q, clr_addr_d;
  logic [DEN_W-1:0]    r_q, r_d;          // current remainder
  logic [POS_W-1:0]    pos_q, pos_d;      // digit position
  logic [POS_W-1:0]    start_q, start_d;
  logic [POS_W-1:0]    cyc_q, cyc_d;
  logic [STORE_AW-1:0] p_q, p_d;
  logic [STORE_AW-1:0] p_last_q, p_last_d;

  logic                out_valid_q;
  kind_e               out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]  out_value_q, out_value_d;
  logic                out_trunc_q, out_trunc_d;
  logic                out_bad_q, out_bad_d;
  logic                out_last_q, out_last_d;
  logic                load_out;
  logic                out_free;

  logic [NUM_W-1:0]    in_num;
  logic [DEN_W-1:0]    in_den;
  logic                in_bad;
  logic                accept;

  logic                div_done;
  logic [NB_USED-1:0]  div_quot;
  logic [DEN_W-1:0]    div_rem;

  logic                tab_rd_en;
  rt_entry_t           tab_rd_data;
  logic                tab_wr_en;
  logic [TAB_AW-1:0]   tab_wr_addr;
  rt_entry_t           tab_wr_data;

  dig_wr_t             dig_wr;
  logic                dig_rd_en;
  logic [DIGIT_W-1:0]  dig_rd_data;

  digit_res_t          step;
  logic [POS_W-1:0]    shown;
  logic [POS_W-1:0]    last_full;

  assign in_num = s_axis_tdata_i[NUM_W-1:0];
  assign in_den = s_axis_tdata_i[NUM_W+DEN_W-1:NUM_W];
  assign in_bad = (in_den == '0) || (32'(in_den) > TABLE_DEPTH);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign step      = digit_step(r_q, den_q);
  assign shown     = (cyc_q < POS_W'(SHOWN_CYCLE_DIGITS)) ? cyc_q
                                                          : POS_W'(SHOWN_CYCLE_DIGITS);
  assign last_full = start_q + shown - POS_W'(1);

  rde_intdiv #(
    .NB (NB_USED)
  ) u_intdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && !in_bad),
    .num_i   (in_num[NB_USED-1:0]),
    .den_i   (in_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  rde_remtable #(
    .DEPTH (TABLE_DEPTH),
    .AW    (TAB_AW)
  ) u_remtable (
    .clk_i     (clk_i),
    .rd_en_i   (tab_rd_en),
    .rd_addr_i (TAB_AW'(r_q)),
    .rd_data_o (tab_rd_data),
    .wr_en_i   (tab_wr_en),
    .wr_addr_i (tab_wr_addr),
    .wr_data_i (tab_wr_data)
  );

  rde_digits u_digits (
    .clk_i     (clk_i),
    .wr_i      (dig_wr),
    .rd_en_i   (dig_rd_en),
    .rd_addr_i (p_q - STORE_AW'(1)),
    .rd_data_o (dig_rd_data)
  );

  always_comb begin
    state_d     = state_q;
    den_d       = den_q;
    bad_d       = bad_q;
    epoch_d     = epoch_q;
    clr_addr_d  = clr_addr_q;
    r_d         = r_q;
    pos_d       = pos_q;
    start_d     = start_q;
    cyc_d       = cyc_q;
    p_d         = p_q;
    p_last_d    = p_last_q;
    tab_rd_en   = 1'b0;
    tab_wr_en   = 1'b0;
    tab_wr_addr = TAB_AW'(r_q);
    tab_wr_data = '{tag: epoch_q, pos: pos_q};
    dig_wr      = '{en: 1'b0, addr: STORE_AW'(pos_q - POS_W'(1)), data: step.digit};
    dig_rd_en   = 1'b0;
    load_out    = 1'b0;
    out_kind_d  = KIND_SUM;
    out_value_d = '0;
    out_trunc_d = 1'b0;
    out_bad_d   = 1'b0;
    out_last_d  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tab_wr_en   = 1'b1;
        tab_wr_addr = clr_addr_q;
        tab_wr_data = '0;
        if (clr_addr_q == TAB_AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + TAB_AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          den_d   = in_den;
          bad_d   = in_bad;
          state_d = in_bad ? ST_EMIT_SUM : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          r_d     = div_rem;
          pos_d   = POS_W'(1);
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        tab_rd_en = 1'b1;
        state_d   = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (tab_rd_data.tag == epoch_q) begin
          // remainder seen before in this fraction: cycle found
          start_d = tab_rd_data.pos;
          cyc_d   = pos_q - tab_rd_data.pos;
          state_d = ST_EMIT_INT;
        end else begin
          tab_wr_en = 1'b1;
          dig_wr.en = (pos_q <= POS_W'(STORE_DEPTH));
          r_d       = step.rem;
          pos_d     = pos_q + POS_W'(1);
          state_d   = ST_WALK_RD;
        end
      end
      ST_EMIT_INT: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_kind_d  = KIND_INT;
          out_value_d = VALUE_W'(div_quot);
          p_d         = STORE_AW'(1);
          p_last_d    = (last_full < POS_W'(MAX_DIGIT_ITEMS)) ? STORE_AW'(last_full)
                                                               : STORE_AW'(MAX_DIGIT_ITEMS);
          state_d     = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        dig_rd_en = 1'b1;
        state_d   = ST_EMIT_DIG;
      end
      ST_EMIT_DIG: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_kind_d  = (POS_W'(p_q) < start_q) ? KIND_PRE : KIND_CYC;
          out_value_d = VALUE_W'(dig_rd_data);
          if (p_q == p_last_q) begin
            state_d = ST_EMIT_SUM;
          end else begin
            p_d     = p_q + STORE_AW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_SUM: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_kind_d  = KIND_SUM;
          out_value_d = bad_q ? '0 : VALUE_W'(cyc_q);
          out_trunc_d = !bad_q && (cyc_q > POS_W'(SHOWN_CYCLE_DIGITS));
          out_bad_d   = bad_q;
          out_last_d  = 1'b1;
          if (bad_q) begin
            state_d = ST_IDLE;
          end else if (epoch_q == '1) begin
            // tags about to repeat: wipe the table first
            epoch_d    = EPOCH_W'(1);
            clr_addr_d = '0;
            state_d    = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + EPOCH_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      epoch_q     <= EPOCH_W'(1);
      clr_addr_q  <= '0;
      bad_q       <= 1'b0;
      r_q         <= '0;
      pos_q       <= '0;
      p_q         <= '0;
      p_last_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      epoch_q    <= epoch_d;
      clr_addr_q <= clr_addr_d;
      bad_q      <= bad_d;
      r_q        <= r_d;
      pos_q      <= pos_d;
      p_q        <= p_d;
      p_last_q   <= p_last_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    start_q <= start_d;
    cyc_q   <= cyc_d;
    if (load_out) begin
      out_kind_q  <= out_kind_d;
      out_value_q <= out_value_d;
      out_trunc_q <= out_trunc_d;
      out_bad_q   <= out_bad_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_bad_q, out_trunc_q, out_value_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
